// ----- rtl/core/dmc_pkg.sv -----
`timescale 1ns / 1ps

package dmc_pkg;

    // Default number of treatment modes
    localparam int NumModesDefault = 4;

    // Device states
    localparam logic [2:0] StOff   = 3'd0;
    localparam logic [2:0] StIdle  = 3'd1;
    localparam logic [2:0] StMsel  = 3'd2;
    localparam logic [2:0] StRun   = 3'd3;
    localparam logic [2:0] StPause = 3'd4;
    localparam logic [2:0] StChg   = 3'd5;
    localparam logic [2:0] StErr   = 3'd6;
    localparam logic [2:0] StShut  = 3'd7;

    // Event opcodes
    localparam logic [4:0] OpTick         = 5'd0;
    localparam logic [4:0] OpPowerShort   = 5'd1;
    localparam logic [4:0] OpPowerLong    = 5'd2;
    localparam logic [4:0] OpPowerVLong   = 5'd3;
    localparam logic [4:0] OpModeShort    = 5'd4;
    localparam logic [4:0] OpChgConnect   = 5'd5;
    localparam logic [4:0] OpChgDisconn   = 5'd6;
    localparam logic [4:0] OpChgComplete  = 5'd7;
    localparam logic [4:0] OpContactOn    = 5'd8;
    localparam logic [4:0] OpContactOff   = 5'd9;
    localparam logic [4:0] OpRemoteMode   = 5'd10;
    localparam logic [4:0] OpRemoteInt    = 5'd11;
    localparam logic [4:0] OpRemoteColor  = 5'd12;
    localparam logic [4:0] OpTempWarn     = 5'd13;
    localparam logic [4:0] OpTempCrit     = 5'd14;
    localparam logic [4:0] OpBattCrit     = 5'd15;
    localparam logic [4:0] OpBattLow      = 5'd16;
    localparam logic [4:0] OpAutoWarn     = 5'd17;
    localparam logic [4:0] OpAutoTimeout  = 5'd18;

    // Error kinds
    localparam logic [1:0] ErrNone     = 2'd0;
    localparam logic [1:0] ErrTempWarn = 2'd1;
    localparam logic [1:0] ErrTempCrit = 2'd2;
    localparam logic [1:0] ErrBattCrit = 2'd3;

    // Stimulator commands
    localparam logic [1:0] StimNone   = 2'd0;
    localparam logic [1:0] StimStop   = 2'd1;
    localparam logic [1:0] StimStart  = 2'd2;
    localparam logic [1:0] StimUpdate = 2'd3;

    // LED colour actions
    localparam logic [1:0] ColNone = 2'd0;
    localparam logic [1:0] ColMode = 2'd1;
    localparam logic [1:0] ColRgb  = 2'd2;

    // LED patterns
    localparam logic [3:0] PatNone      = 4'd0;
    localparam logic [3:0] PatBreathe   = 4'd1;
    localparam logic [3:0] PatFastBlink = 4'd2;
    localparam logic [3:0] PatSlowBlink = 4'd3;
    localparam logic [3:0] PatBlink100  = 4'd4;
    localparam logic [3:0] PatFadeOut   = 4'd5;
    localparam logic [3:0] PatOff       = 4'd6;
    localparam logic [3:0] PatBattery   = 4'd7;
    localparam logic [3:0] PatBright    = 4'd8;

    // Vibration patterns
    localparam logic [2:0] VibNone   = 3'd0;
    localparam logic [2:0] Vib200    = 3'd1;
    localparam logic [2:0] Vib100    = 3'd2;
    localparam logic [2:0] Vib50     = 3'd3;
    localparam logic [2:0] Vib200x3  = 3'd4;
    localparam logic [2:0] Vib150x2  = 3'd5;
    localparam logic [2:0] Vib100x2  = 3'd6;

    // Session actions
    localparam logic [1:0] SessNone  = 2'd0;
    localparam logic [1:0] SessStart = 2'd1;
    localparam logic [1:0] SessEnd   = 2'd2;
    localparam logic [1:0] SessShot  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CfgIdleSleep   = 3'd0;
    localparam logic [2:0] CfgMselTimeout = 3'd1;
    localparam logic [2:0] CfgPauseTime   = 3'd2;
    localparam logic [2:0] CfgPauseResume = 3'd3;
    localparam logic [2:0] CfgFadeOut     = 3'd4;
    localparam logic [2:0] CfgTempDelay   = 3'd5;
    localparam logic [2:0] CfgTempTenths  = 3'd6;

    // Configuration reset values
    localparam logic [31:0]        RstIdleSleep   = 32'd180000;
    localparam logic [31:0]        RstMselTimeout = 32'd10000;
    localparam logic [31:0]        RstPauseTime   = 32'd10000;
    localparam logic [31:0]        RstPauseResume = 32'd3000;
    localparam logic [31:0]        RstFadeOut     = 32'd1000;
    localparam logic [31:0]        RstTempDelay   = 32'd30000;
    localparam logic signed [11:0] RstTempTenths  = 12'sd400;

    // Colours and intensity range
    localparam logic [23:0] RgbRed    = 24'hFF0000;
    localparam logic [23:0] RgbOrange = 24'hFF6400;
    localparam logic [2:0]  IntMin    = 3'd1;
    localparam logic [2:0]  IntMax    = 3'd5;

    // Brightness level for an intensity step: intensity times 51
    function automatic logic [7:0] level_of(input logic [2:0] lv);
        logic [10:0] prod;
        prod = 11'(lv) * 11'd51;
        return prod[7:0];
    endfunction

endpackage

// ----- rtl/core/device_mode_controller.sv -----
// Timing: a result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle; a single result register decouples the
// two sides, so a new item is taken whenever the result is empty or taken.
// Reset: synchronous, active low; clears the state, the session total and
// the output valid, and loads the configuration registers with defaults.
`timescale 1ns / 1ps

module device_mode_controller #(
    parameter int NUM_MODES = dmc_pkg::NumModesDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [4:0]         i_opcode,
    input  logic [23:0]        i_data,
    input  logic [31:0]        i_now_ms,
    input  logic [6:0]         i_battery_percent,
    input  logic               i_temp_connected,
    input  logic signed [11:0] i_temperature_tenths,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_device_state,
    output logic [1:0]         o_mode,
    output logic [2:0]         o_intensity,
    output logic [1:0]         o_error_kind,
    output logic [1:0]         o_stim_command,
    output logic [1:0]         o_led_color_action,
    output logic [23:0]        o_led_rgb,
    output logic [3:0]         o_led_pattern,
    output logic [7:0]         o_led_level,
    output logic [2:0]         o_vibration_pattern,
    output logic [1:0]         o_session_action,
    output logic [31:0]        o_session_total_ms,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    import dmc_pkg::*;

    typedef struct packed {
        logic [1:0]  stim;
        logic [1:0]  cact;
        logic [23:0] rgb;
        logic [3:0]  pat;
        logic [7:0]  lvl;
        logic [2:0]  vib;
        logic [1:0]  sess;
    } t_cmd;

    localparam bit         ModeIsPow2 = ((NUM_MODES & (NUM_MODES - 1)) == 0);
    localparam logic [1:0] ModeLast   = 2'(NUM_MODES - 1);

    // Configuration registers
    logic [31:0]        r_idle_sleep;
    logic [31:0]        r_msel_timeout;
    logic [31:0]        r_pause_time;
    logic [31:0]        r_pause_resume;
    logic [31:0]        r_fade_out;
    logic [31:0]        r_temp_delay;
    logic signed [11:0] r_temp_tenths;

    // Controller state
    logic [2:0]  r_state,     n_state;
    logic [1:0]  r_mode,      n_mode;
    logic [2:0]  r_intensity, n_intensity;
    logic [1:0]  r_err,       n_err;
    logic [31:0] r_enter,     n_enter;
    logic [31:0] r_touch,     n_touch;
    logic [31:0] r_run_start, n_run_start;
    logic [31:0] r_total,     n_total;
    logic        r_sess_open, n_sess_open;

    // Result register
    logic        r_out_valid;
    logic [2:0]  r_out_state;
    logic [1:0]  r_out_mode;
    logic [2:0]  r_out_intensity;
    logic [1:0]  r_out_err;
    t_cmd        r_out_cmd;
    logic [31:0] r_out_total;

    logic        in_accept;
    t_cmd        cmd;
    logic        go_en;
    logic [2:0]  go_ns;
    logic [31:0] el_enter;
    logic [31:0] el_touch;
    logic [7:0]  remote_lv;
    logic [1:0]  data_mode;
    logic [1:0]  mode_next;
    logic [3:0]  grp_sum [4];
    logic [5:0]  dig_sum;
    logic [3:0]  fold_sum;
    logic [1:0]  mod3;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    // Remainder of the payload by three: base-four digits summed, then folded
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            grp_sum[k] = 4'(i_data[6*k +: 2]) + 4'(i_data[6*k+2 +: 2])
                       + 4'(i_data[6*k+4 +: 2]);
        end
        dig_sum  = 6'(grp_sum[0]) + 6'(grp_sum[1]) + 6'(grp_sum[2]) + 6'(grp_sum[3]);
        fold_sum = 4'(dig_sum[1:0]) + 4'(dig_sum[3:2]) + 4'(dig_sum[5:4]);
        if (fold_sum >= 4'd6) begin
            mod3 = 2'(fold_sum - 4'd6);
        end else if (fold_sum >= 4'd3) begin
            mod3 = 2'(fold_sum - 4'd3);
        end else begin
            mod3 = fold_sum[1:0];
        end
    end

    // Mode chosen by the payload, and the next mode in the cycle
    assign data_mode = ModeIsPow2 ? (i_data[1:0] & ModeLast) : mod3;
    assign mode_next = (r_mode == ModeLast) ? 2'd0 : r_mode + 2'd1;

    assign el_enter  = i_now_ms - r_enter;
    assign el_touch  = i_now_ms - r_touch;
    assign remote_lv = i_data[7:0];

    // Next state and commands for the item on the input
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_intensity = r_intensity;
        n_err       = r_err;
        n_enter     = r_enter;
        n_touch     = r_touch;
        n_run_start = r_run_start;
        n_total     = r_total;
        n_sess_open = r_sess_open;
        cmd         = '0;
        go_en       = 1'b0;
        go_ns       = r_state;

        if (i_opcode == OpRemoteColor) begin
            cmd.cact = ColRgb;
            cmd.rgb  = i_data;
        end else if (i_opcode == OpTick) begin
            // Timeout checks
            case (r_state)
                StIdle: begin
                    if (el_touch >= r_idle_sleep) begin
                        go_en = 1'b1; go_ns = StShut;
                    end
                end
                StMsel: begin
                    if (el_touch >= r_msel_timeout) begin
                        go_en = 1'b1; go_ns = StIdle;
                    end
                end
                StPause: begin
                    if (el_enter >= r_pause_time) begin
                        go_en = 1'b1; go_ns = StIdle;
                    end
                end
                StShut: begin
                    if (el_enter >= r_fade_out) begin
                        go_en = 1'b1; go_ns = StOff;
                    end
                end
                StErr: begin
                    if (r_err == ErrTempWarn && el_enter >= r_temp_delay &&
                        (!i_temp_connected || i_temperature_tenths <= r_temp_tenths)) begin
                        n_err = ErrNone;
                        go_en = 1'b1; go_ns = StIdle;
                    end else if (r_err == ErrTempCrit || r_err == ErrBattCrit) begin
                        go_en = 1'b1; go_ns = StShut;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            // Events
            case (r_state)
                StOff: begin
                    if (i_opcode == OpPowerLong) begin
                        go_en = 1'b1; go_ns = StIdle;
                    end else if (i_opcode == OpChgConnect) begin
                        go_en = 1'b1; go_ns = StChg;
                    end
                end
                StIdle: begin
                    if (i_opcode == OpModeShort) begin
                        n_touch = i_now_ms;
                        go_en = 1'b1; go_ns = StMsel;
                    end else if (i_opcode == OpRemoteMode) begin
                        n_mode   = data_mode;
                        n_touch  = i_now_ms;
                        cmd.cact = ColMode;
                        go_en = 1'b1; go_ns = StMsel;
                    end else if (i_opcode == OpPowerVLong) begin
                        go_en = 1'b1; go_ns = StShut;
                    end else if (i_opcode == OpChgConnect) begin
                        go_en = 1'b1; go_ns = StChg;
                    end
                end
                StMsel: begin
                    if (i_opcode == OpModeShort || i_opcode == OpRemoteMode) begin
                        n_mode   = (i_opcode == OpModeShort) ? mode_next : data_mode;
                        n_touch  = i_now_ms;
                        cmd.cact = ColMode;
                        cmd.vib  = Vib100;
                    end else if (i_opcode == OpPowerShort) begin
                        n_intensity = IntMin;
                        go_en = 1'b1; go_ns = StRun;
                    end else if (i_opcode == OpPowerVLong) begin
                        go_en = 1'b1; go_ns = StShut;
                    end
                end
                StRun: begin
                    if (i_opcode == OpModeShort ||
                        (i_opcode == OpRemoteInt && remote_lv >= 8'(IntMin) &&
                         remote_lv <= 8'(IntMax))) begin
                        // Intensity step or remote intensity
                        if (i_opcode == OpModeShort) begin
                            n_intensity = (r_intensity >= IntMax) ? IntMin
                                                                  : r_intensity + 3'd1;
                        end else begin
                            n_intensity = remote_lv[2:0];
                        end
                        n_touch  = i_now_ms;
                        cmd.stim = StimUpdate;
                        cmd.pat  = PatBright;
                        cmd.lvl  = level_of(n_intensity);
                        cmd.vib  = Vib50;
                        cmd.sess = SessShot;
                    end else if (i_opcode == OpContactOff) begin
                        go_en = 1'b1; go_ns = StPause;
                    end else if (i_opcode == OpChgConnect) begin
                        go_en = 1'b1; go_ns = StChg;
                    end else if (i_opcode == OpPowerVLong || i_opcode == OpAutoTimeout) begin
                        go_en = 1'b1; go_ns = StShut;
                    end else if (i_opcode == OpTempWarn || i_opcode == OpTempCrit ||
                                 i_opcode == OpBattCrit) begin
                        n_err = 2'(i_opcode - OpRemoteColor);
                        go_en = 1'b1; go_ns = StErr;
                    end else if (i_opcode == OpAutoWarn) begin
                        cmd.vib = Vib150x2;
                    end else if (i_opcode == OpBattLow) begin
                        cmd.cact = ColRgb;
                        cmd.rgb  = RgbOrange;
                        cmd.pat  = PatSlowBlink;
                        cmd.vib  = Vib100x2;
                    end
                end
                StPause: begin
                    if (i_opcode == OpContactOn) begin
                        go_en = 1'b1;
                        go_ns = (el_enter < r_pause_resume) ? StRun : StIdle;
                    end else if (i_opcode == OpPowerShort) begin
                        go_en = 1'b1; go_ns = StIdle;
                    end else if (i_opcode == OpPowerVLong) begin
                        go_en = 1'b1; go_ns = StShut;
                    end
                end
                StChg: begin
                    if (i_opcode == OpChgDisconn || i_opcode == OpChgComplete) begin
                        go_en = 1'b1; go_ns = StIdle;
                    end
                end
                StErr: begin
                    if (i_opcode == OpPowerVLong) begin
                        go_en = 1'b1; go_ns = StShut;
                    end
                end
                default: begin
                end
            endcase
        end

        // State transition: exit actions of the old state, entry of the new
        if (go_en && go_ns != r_state) begin
            if (r_state == StRun) begin
                n_total = r_total + (i_now_ms - r_run_start);
                if (go_ns != StPause) begin
                    n_sess_open = 1'b0;
                    cmd.sess    = SessEnd;
                end
                cmd.stim = StimStop;
            end else if (r_state == StPause) begin
                if (go_ns != StRun && r_sess_open) begin
                    n_sess_open = 1'b0;
                    cmd.sess    = SessEnd;
                end
            end
            n_state = go_ns;
            n_enter = i_now_ms;
            case (go_ns)
                StIdle: begin
                    n_touch  = i_now_ms;
                    cmd.cact = ColMode;
                    cmd.pat  = PatBreathe;
                    if (r_state == StOff) begin
                        cmd.vib = Vib200;
                    end
                end
                StMsel: begin
                    cmd.cact = ColMode;
                    cmd.pat  = PatFastBlink;
                    cmd.vib  = Vib100;
                end
                StRun: begin
                    n_run_start = i_now_ms;
                    if (!n_sess_open) begin
                        n_sess_open = 1'b1;
                        cmd.sess    = SessStart;
                    end
                    cmd.stim = StimStart;
                    cmd.cact = ColMode;
                    cmd.pat  = PatBright;
                    cmd.lvl  = level_of(n_intensity);
                end
                StPause: begin
                    cmd.stim = StimStop;
                    cmd.pat  = PatSlowBlink;
                end
                StChg: begin
                    cmd.stim = StimStop;
                    cmd.pat  = PatBattery;
                end
                StErr: begin
                    cmd.stim = StimStop;
                    cmd.cact = ColRgb;
                    cmd.rgb  = RgbRed;
                    cmd.pat  = PatBlink100;
                    cmd.vib  = Vib200x3;
                end
                StShut: begin
                    cmd.stim = StimStop;
                    cmd.pat  = PatFadeOut;
                    cmd.vib  = Vib100;
                end
                default: begin
                    cmd.pat = PatOff;
                end
            endcase
        end

        // Level and colour fields only carry meaning for their own codes
        if (cmd.pat == PatBattery) begin
            cmd.lvl = 8'(i_battery_percent);
        end else if (cmd.pat != PatBright) begin
            cmd.lvl = '0;
        end
        if (cmd.cact != ColRgb) begin
            cmd.rgb = '0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_sleep   <= RstIdleSleep;
            r_msel_timeout <= RstMselTimeout;
            r_pause_time   <= RstPauseTime;
            r_pause_resume <= RstPauseResume;
            r_fade_out     <= RstFadeOut;
            r_temp_delay   <= RstTempDelay;
            r_temp_tenths  <= RstTempTenths;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CfgIdleSleep:   r_idle_sleep   <= i_cfg_data;
                CfgMselTimeout: r_msel_timeout <= i_cfg_data;
                CfgPauseTime:   r_pause_time   <= i_cfg_data;
                CfgPauseResume: r_pause_resume <= i_cfg_data;
                CfgFadeOut:     r_fade_out     <= i_cfg_data;
                CfgTempDelay:   r_temp_delay   <= i_cfg_data;
                CfgTempTenths:  r_temp_tenths  <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StOff;
            r_mode      <= 2'd0;
            r_intensity <= IntMin;
            r_err       <= ErrNone;
            r_enter     <= '0;
            r_touch     <= '0;
            r_run_start <= '0;
            r_total     <= '0;
            r_sess_open <= 1'b0;
        end else if (in_accept) begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_intensity <= n_intensity;
            r_err       <= n_err;
            r_enter     <= n_enter;
            r_touch     <= n_touch;
            r_run_start <= n_run_start;
            r_total     <= n_total;
            r_sess_open <= n_sess_open;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_state     <= n_state;
            r_out_mode      <= n_mode;
            r_out_intensity <= n_intensity;
            r_out_err       <= n_err;
            r_out_cmd       <= cmd;
            r_out_total     <= n_total;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_device_state      = r_out_state;
    assign o_mode              = r_out_mode;
    assign o_intensity         = r_out_intensity;
    assign o_error_kind        = r_out_err;
    assign o_stim_command      = r_out_cmd.stim;
    assign o_led_color_action  = r_out_cmd.cact;
    assign o_led_rgb           = r_out_cmd.rgb;
    assign o_led_pattern       = r_out_cmd.pat;
    assign o_led_level         = r_out_cmd.lvl;
    assign o_vibration_pattern = r_out_cmd.vib;
    assign o_session_action    = r_out_cmd.sess;
    assign o_session_total_ms  = r_out_total;

endmodule

// ----- rtl/core/dmc_checker.sv -----
`timescale 1ns / 1ps

module dmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_device_state,
    input logic [1:0]  o_led_color_action,
    input logic [23:0] o_led_rgb,
    input logic [3:0]  o_led_pattern,
    input logic [7:0]  o_led_level,
    input logic [31:0] o_session_total_ms
);

    import dmc_pkg::*;

    // An accepted item shows its result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted item gave no result in the next cycle");

    // An empty result register never holds the input back
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while no result was waiting");

    // A stalled result keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_device_state) && $stable(o_session_total_ms)))
        else $error("stalled result changed or was dropped");

    // The LED level is only meaningful for the battery and brightness patterns
    a_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_led_pattern != PatBattery && o_led_pattern != PatBright)
            |-> (o_led_level == 8'd0))
        else $error("LED level set for a pattern that does not use it");

    // The RGB value is only meaningful with an explicit colour action
    a_rgb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_led_color_action != ColRgb) |-> (o_led_rgb == 24'd0))
        else $error("RGB value set without an explicit colour action");

endmodule

bind device_mode_controller dmc_checker u_dmc_checker (.*);
